// ----- rtl/bf3hs_pkg.sv -----
package bf3hs_pkg;

    // Unsigned Q1.15: 32768 is 1.0.
    localparam int          VAL_W   = 16;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // Sum of nine Q1.15 values plus the rounding term stays below 2^19.
    localparam int          SUM_W   = 19;

    // floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT for every x below 2^19.
    localparam int          DIV9_SHIFT = 22;
    localparam logic [18:0] DIV9_MUL   = 19'd466034;
    localparam int          PROD_W     = SUM_W + 19;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic
    {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [15:0] cell_value;
        logic        force_hot;
        logic        is_padding;
    } cell_item_t;

    typedef struct packed
    {
        logic [15:0] result_value;
        logic        frame_last;
    } result_item_t;

endpackage

// ----- rtl/box_filter_3x3_heat_step_core.sv -----
// One round of a heat diffusion step: cells stream in raster order, one transfer per clock
// unless stalled, and each result is the rounded mean of the cell's 3x3 neighbourhood with zero
// outside the grid. Hot cells enter as 1.0, padding cells as 0, and values above 1.0 are
// saturated. Two line buffers of MAX_WIDTH entries hold the rows above the current column, so
// the result for a cell is complete once grid_width+1 further cells have arrived; after the grid
// the host sends grid_width+1 padding transfers to drain the last results. The block sustains
// one cell per clock unless the output stalls: every stage is a single register and the line
// buffers take one read and one write per cycle. A result is built in the stage 1, window and
// sum registers and leaves from the output register. After reset the line buffers are swept to
// zero, during which cell_stall is held high; register writes are taken as usual. Any write to
// grid_width or grid_height starts a new frame, as does the result flagged frame_last.
module box_filter_3x3_heat_step_core
    import bf3hs_pkg::*;
#(
    parameter int MAX_WIDTH = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cell_valid,
    output logic                 cell_stall,
    input  cell_item_t           cell_data,

    output logic                 result_valid,
    input  logic                 result_stall,
    output result_item_t         result,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    // Which neighbourhood rows and columns fall outside the grid for one result.
    typedef struct packed
    {
        logic top;
        logic bot;
        logic left;
        logic right;
        logic last;
    } nbhd_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0]  grid_width_reg;
    logic [15:0] grid_height_reg;
    logic        cfg_wr;
    reg_idx_t    reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 9'd64;
            grid_height_reg <= 16'd64;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[8:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[15:0];
            endcase
        end
    end

    // Effective grid size: a width of zero counts as one, and anything above the line
    // buffer depth counts as the depth; a height of zero counts as one.
    logic [WW-1:0] eff_w;
    logic [15:0]   eff_h;

    always_comb
    begin
        if (grid_width_reg == '0)
            eff_w = WW'(1);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(grid_width_reg);
    end

    assign eff_h = (grid_height_reg == '0) ? 16'd1 : grid_height_reg;

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic          clearing_reg;
    logic [CW-1:0] clr_addr_reg;
    logic          s1_valid_reg;
    logic          s2_valid_reg;
    logic          s3_valid_reg;
    logic          out_valid_reg;
    logic          adv;
    logic          acc;

    // All stages move together. They stop only when the last stage holds a result and the
    // output register is full and stalled; an item with no result never holds them up.
    assign adv        = !out_valid_reg || !result_stall || !s3_valid_reg;
    assign cell_stall = clearing_reg || !adv;
    assign acc        = cell_valid && !cell_stall;

    // ------------------------------------------------------------------
    // Input stage: position counters and neighbourhood edges
    // ------------------------------------------------------------------
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [1:0]    in_row_reg,  in_row_next;   // saturates at 2: only rows 0, 1 and later matter
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [15:0]   out_row_reg, out_row_next;

    logic [CW-1:0] acc_col;
    logic [WW-1:0] col_inc;
    logic [WW-1:0] out_col_inc;
    logic          acc_due;
    nbhd_t         acc_nb;
    logic [15:0]   acc_v;

    assign acc_col     = ({1'b0, in_col_reg} >= eff_w) ? '0 : in_col_reg;
    assign col_inc     = {1'b0, acc_col} + WW'(1);
    assign out_col_inc = {1'b0, out_col_reg} + WW'(1);
    assign acc_due     = (in_row_reg == 2'd2) || ((in_row_reg == 2'd1) && (acc_col != '0));

    always_comb
    begin
        acc_nb.top   = (out_row_reg == '0);
        acc_nb.bot   = ({1'b0, out_row_reg} + 17'd1) >= {1'b0, eff_h};
        acc_nb.left  = (out_col_reg == '0);
        acc_nb.right = (out_col_inc >= eff_w);
        acc_nb.last  = acc_nb.bot && acc_nb.right;
    end

    // Padding wins over a hot flag; ordinary values saturate at 1.0.
    always_comb
    begin
        if (cell_data.is_padding)
            acc_v = '0;
        else if (cell_data.force_hot)
            acc_v = ONE_Q15;
        else if (cell_data.cell_value > ONE_Q15)
            acc_v = ONE_Q15;
        else
            acc_v = cell_data.cell_value;
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (acc)
        begin
            if (col_inc >= eff_w)
            begin
                in_col_next = '0;
                if (in_row_reg != 2'd2)
                    in_row_next = in_row_reg + 2'd1;
            end
            else
            begin
                in_col_next = col_inc[CW-1:0];
            end

            if (acc_due)
            begin
                if (acc_nb.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_inc >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 16'd1;
                end
                else
                begin
                    out_col_next = out_col_inc[CW-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffers
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] upper_mem  [MAX_WIDTH];
    logic [VAL_W-1:0] middle_mem [MAX_WIDTH];
    logic [VAL_W-1:0] rd_up_reg;
    logic [VAL_W-1:0] rd_mid_reg;

    logic [VAL_W-1:0] s1_v_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_due_reg;
    nbhd_t            s1_nb_reg;

    // With a one-cell row, or when a new frame starts right behind the last cell of the
    // previous one, the next cell reads the entry that the cell ahead writes at the same
    // edge, so the written values are carried across directly.
    logic             fwd_reg;
    logic [VAL_W-1:0] fwd_up_reg;
    logic [VAL_W-1:0] fwd_mid_reg;

    logic [VAL_W-1:0] s1_up;
    logic [VAL_W-1:0] s1_mid;
    logic             mem_we;
    logic [CW-1:0]    mem_addr;
    logic [VAL_W-1:0] up_wdata;
    logic [VAL_W-1:0] mid_wdata;

    assign s1_up  = fwd_reg ? fwd_up_reg  : rd_up_reg;
    assign s1_mid = fwd_reg ? fwd_mid_reg : rd_mid_reg;

    assign mem_we    = clearing_reg || (adv && s1_valid_reg);
    assign mem_addr  = clearing_reg ? clr_addr_reg : s1_col_reg;
    assign up_wdata  = clearing_reg ? '0 : s1_mid;
    assign mid_wdata = clearing_reg ? '0 : s1_v_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[mem_addr]  <= up_wdata;
            middle_mem[mem_addr] <= mid_wdata;
        end
        if (acc)
        begin
            rd_up_reg  <= upper_mem[acc_col];
            rd_mid_reg <= middle_mem[acc_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_v_reg    <= acc_v;
            s1_col_reg  <= acc_col;
            s1_due_reg  <= acc_due;
            s1_nb_reg   <= acc_nb;
            fwd_up_reg  <= s1_mid;
            fwd_mid_reg <= s1_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Window, sum and divide stages
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] win_reg [3][3];
    nbhd_t            s2_nb_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             s3_last_reg;
    logic [PROD_W-1:0] prod;
    result_item_t     result_reg;

    always_comb
    begin
        sum_next = SUM_W'(4);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!((r == 0) && s2_nb_reg.top) && !((r == 2) && s2_nb_reg.bot) &&
                    !((c == 0) && s2_nb_reg.left) && !((c == 2) && s2_nb_reg.right))
                    sum_next = sum_next + SUM_W'(win_reg[r][c]);
            end
        end
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(DIV9_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
            end
        end
        else if (adv && s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= s1_up;
            win_reg[1][2] <= s1_mid;
            win_reg[2][2] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_nb_reg   <= s1_nb_reg;
            sum_reg     <= sum_next;
            s3_last_reg <= s2_nb_reg.last;
        end
        if (adv && s3_valid_reg)
        begin
            result_reg.result_value <= prod[DIV9_SHIFT +: VAL_W];
            result_reg.frame_last   <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                    clearing_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + CW'(1);
            end

            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;

            if (acc)
                fwd_reg <= s1_valid_reg && (s1_col_reg == acc_col);

            if (adv)
            begin
                s1_valid_reg <= acc;
                s2_valid_reg <= s1_valid_reg && s1_due_reg;
                s3_valid_reg <= s2_valid_reg;
            end

            if (adv && s3_valid_reg)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fwd_only_single_column: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s1_valid_reg && (s1_col_reg == acc_col)) |->
            ((eff_w == WW'(1)) || (acc_col == '0)))
        else $error("line buffer read after write of the same entry away from column zero");

    a_out_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, out_row_reg} < {1'b0, eff_h}) && ({1'b0, out_col_reg} < eff_w))
        else $error("output position outside the grid");

    a_in_row_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg != 2'd3)
        else $error("input row counter passed its saturation value");

    a_pipe_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg))
        else $error("item in flight during the line buffer sweep");

endmodule

// ----- tb/sv/box_filter_3x3_heat_step_core_tb.sv -----
// Testbench for the 3x3 heat step filter.
//
// A behavioural copy of the filter runs beside the block. Every cell transfer that the block
// takes is pushed through it, and whatever result that cell completes is queued. A checking
// process compares each result transfer, field by field, with the oldest queued result.
//
// The run is a sequence of tests: the register values after reset, a short list of hand-made
// cases, random frames of small grids (mostly well-formed, some cut short), the largest and
// most degenerate grid sizes, and a final pair of frames at full rate with no idling at all.
module box_filter_3x3_heat_step_core_tb;

    import bf3hs_pkg::*;

    localparam int MAX_W = 256;

    logic                clk;
    logic                rst_n;
    logic                cell_valid;
    logic                cell_stall;
    cell_item_t          cell_data;
    logic                result_valid;
    logic                result_stall;
    result_item_t        result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    box_filter_3x3_heat_step_core #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow copy of the filter: registers, line buffers, window and the input and output
    // positions within the current frame.
    logic [8:0]   grid_w;
    logic [15:0]  grid_h;
    logic [15:0]  upper_line [MAX_W];
    logic [15:0]  middle_line [MAX_W];
    logic [15:0]  window [3][3];
    int unsigned  in_col;
    int unsigned  in_row;
    int unsigned  out_col;
    int unsigned  out_row;

    // Results still owed by the block, oldest first.
    result_item_t expected_heat [$];

    int failures;

    // Chance, in percent, that the sender inserts a gap before a transfer or that the
    // receiver starts a stall burst. Zero means both sides run flat out.
    int idle_pct;
    int stall_left;

    always #5 clk = ~clk;

    // Effective grid size: a width of 0 counts as 1 and anything above the line buffer
    // depth counts as the depth; a height of 0 counts as 1.
    function automatic int unsigned eff_width();
        if (grid_w == 0)
            return 1;
        if (grid_w > MAX_W)
            return MAX_W;
        return grid_w;
    endfunction

    function automatic int unsigned eff_height();
        return (grid_h == 0) ? 1 : grid_h;
    endfunction

    task automatic restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic reset_shadow();
        int i;
        int j;
        grid_w = 9'd64;
        grid_h = 16'd64;
        for (i = 0; i < MAX_W; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                window[i][j] = '0;
        restart_frame();
    endtask

    // Any write to either register starts a new frame, even if the value is unchanged.
    task automatic apply_register(input reg_idx_t idx, input logic [31:0] data);
        if (idx == REG_GRID_WIDTH)
            grid_w = data[8:0];
        else
            grid_h = data[15:0];
        restart_frame();
    endtask

    // Advance the shadow filter by one accepted cell and queue the result it completes.
    task automatic filter_cell(input cell_item_t c);
        int unsigned   w;
        int unsigned   h;
        int unsigned   col;
        int unsigned   v;
        int unsigned   acc;
        int            i;
        int            j;
        bit            due;
        result_item_t  res;
        w   = eff_width();
        h   = eff_height();
        col = (in_col >= w) ? 0 : in_col;

        // Padding wins over the hot flag; otherwise the value saturates at 1.0.
        if (c.is_padding)
            v = 0;
        else if (c.force_hot)
            v = ONE_Q15;
        else
        begin
            v = c.cell_value;
            if (v > ONE_Q15)
                v = ONE_Q15;
        end

        for (i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2]     = upper_line[col];
        window[1][2]     = middle_line[col];
        window[2][2]     = v[15:0];
        upper_line[col]  = middle_line[col];
        middle_line[col] = v[15:0];

        // The first result of a frame needs grid_width+2 cells to have arrived.
        due = (in_row >= 2) || (in_row == 1 && col >= 1);

        col++;
        if (col >= w)
        begin
            col = 0;
            if (in_row < 32'h1FFFF)
                in_row++;
        end
        in_col = col;

        if (due)
        begin
            // Neighbours outside the grid count as zero.
            acc = 0;
            for (i = 0; i < 3; i++)
                if (!(i == 0 && out_row == 0) && !(i == 2 && out_row + 1 >= h))
                    for (j = 0; j < 3; j++)
                        if (!(j == 0 && out_col == 0) && !(j == 2 && out_col + 1 >= w))
                            acc += window[i][j];
            res.result_value = 16'((acc + 4) / 9);
            res.frame_last   = (out_row + 1 >= h) && (out_col + 1 >= w);
            expected_heat.insert(expected_heat.size(), res);
            if (res.frame_last)
                restart_frame();
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endtask

    // Receiver: stall bursts started at random while idling is enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 7);
        end
        else
            result_stall <= 1'b0;
    end

    // Every result transfer is checked against the oldest queued result.
    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_heat.size() == 0)
            begin
                $error("unexpected result transfer: result_value %0d frame_last %0b",
                       result.result_value, result.frame_last);
                failures++;
            end
            else
            begin
                want = expected_heat.pop_front();
                if (result.result_value !== want.result_value)
                begin
                    $error("result_value: expected %0d, actual %0d",
                           want.result_value, result.result_value);
                    failures++;
                end
                if (result.frame_last !== want.frame_last)
                begin
                    $error("frame_last: expected %0b, actual %0b",
                           want.frame_last, result.frame_last);
                    failures++;
                end
            end
        end
    end

    // Offer one cell, possibly after a gap, and hold it until the block takes it. The valid
    // line is left high so that transfers can follow back to back.
    task automatic send_cell(input cell_item_t c);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            cell_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cell_valid <= 1'b1;
        cell_data  <= c;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        filter_cell(c);
    endtask

    function automatic cell_item_t make_cell(input logic [15:0] value, input logic hot,
                                             input logic pad);
        cell_item_t c;
        c.cell_value = value;
        c.force_hot  = hot;
        c.is_padding = pad;
        return c;
    endfunction

    // Mostly legal heat values, with some above 1.0, the two ends, hot cells and the odd
    // padding cell in the middle of the grid.
    function automatic cell_item_t random_cell();
        cell_item_t c;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            c.cell_value = 16'($urandom_range(0, 32768));
        else if (pick < 16)
            c.cell_value = 16'($urandom);
        else if (pick < 18)
            c.cell_value = ONE_Q15;
        else
            c.cell_value = 16'd0;
        c.force_hot  = ($urandom_range(0, 7) == 0);
        c.is_padding = ($urandom_range(0, 31) == 0);
        return c;
    endfunction

    function automatic cell_item_t drain_cell();
        return make_cell(16'($urandom), 1'($urandom), 1'b1);
    endfunction

    // Drop valid and hold the sender back until the block has delivered every owed result.
    task automatic wait_results_drained();
        @(negedge clk);
        cell_valid <= 1'b0;
        while (expected_heat.size() != 0)
            @(negedge clk);
    endtask

    // Cells that complete no result may still be inside the pipeline once the queue is
    // empty, so settle waits on past that point before the registers are touched.
    task automatic settle();
        wait_results_drained();
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input reg_idx_t idx);
        logic [31:0] want;
        logic [31:0] got;
        want = (idx == REG_GRID_WIDTH) ? {23'd0, grid_w} : {16'd0, grid_h};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", idx.name(), want, got);
            failures++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Set a new grid shape once the block is idle. Bits above each register's width carry
    // random junk half of the time; the read-back must show only the register bits.
    task automatic set_grid(input logic [8:0] wv, input logic [15:0] hv);
        logic [31:0] junk;
        settle();
        junk = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(REG_GRID_WIDTH, (junk & ~32'h1FF) | wv);
        junk = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(REG_GRID_HEIGHT, (junk & ~32'hFFFF) | hv);
        check_register(REG_GRID_WIDTH);
        check_register(REG_GRID_HEIGHT);
    endtask

    // One whole frame at the current shape followed by grid_width+1 drain transfers.
    task automatic send_frame(input bit pause_midway);
        int cells;
        int i;
        cells = eff_width() * eff_height();
        for (i = 0; i < cells; i++)
        begin
            if (pause_midway && i == cells / 2)
                wait_results_drained();
            send_cell(random_cell());
        end
        for (i = 0; i <= eff_width(); i++)
            send_cell(drain_cell());
    endtask

    task automatic send_random_cells(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_cell($urandom_range(0, 5) == 0 ? drain_cell() : random_cell());
    endtask

    task automatic test_reset_values();
        check_register(REG_GRID_WIDTH);
        check_register(REG_GRID_HEIGHT);
    endtask

    // Hand-made cases: value extremes and saturation, a hot cell, padding inside the grid,
    // a hot padding cell, and the degenerate sizes: width and height written as 0, width 1, height 1.
    task automatic test_directed_cases();
        idle_pct = 25;
        set_grid(9'd3, 16'd2);
        send_cell(make_cell(16'd0,     1'b0, 1'b0));
        send_cell(make_cell(16'hFFFF,  1'b0, 1'b0));
        send_cell(make_cell(ONE_Q15,   1'b0, 1'b0));
        send_cell(make_cell(16'd0,     1'b1, 1'b0));
        send_cell(make_cell(16'd12345, 1'b0, 1'b1));
        send_cell(make_cell(ONE_Q15,   1'b1, 1'b1));
        send_cell(make_cell(16'hFFFF,  1'b1, 1'b1));
        send_cell(make_cell(16'd0,     1'b0, 1'b1));
        send_cell(make_cell(16'd32769, 1'b0, 1'b1));
        send_cell(make_cell(16'd1,     1'b0, 1'b1));

        set_grid(9'd0, 16'd0);
        send_cell(make_cell(16'd32769, 1'b0, 1'b0));
        send_cell(make_cell(16'd0,     1'b0, 1'b1));
        send_cell(make_cell(16'd0,     1'b1, 1'b1));

        set_grid(9'd1, 16'd3);
        send_cell(make_cell(16'd1,     1'b0, 1'b0));
        send_cell(make_cell(16'd32767, 1'b0, 1'b0));
        send_cell(make_cell(16'd0,     1'b1, 1'b0));
        send_cell(make_cell(16'd0,     1'b0, 1'b1));
        send_cell(make_cell(16'd0,     1'b0, 1'b1));

        set_grid(9'd2, 16'd1);
        send_cell(make_cell(16'd100,   1'b0, 1'b0));
        send_cell(make_cell(16'd200,   1'b0, 1'b0));
        send_cell(make_cell(16'd0,     1'b0, 1'b1));
        send_cell(make_cell(16'd0,     1'b0, 1'b1));
        send_cell(make_cell(16'd0,     1'b0, 1'b1));
    endtask

    // Small random grids. Most frames are complete and properly drained, sometimes several
    // in a row at one shape so that frame_last alone starts the next frame; the rest are cut
    // short at a random point or run on past the drain, and are followed by a register write.
    task automatic test_random_frames();
        int  sent;
        int  cells;
        int  n;
        int  odds;
        bit  keep;
        bit  first;
        logic [8:0]  wv;
        logic [15:0] hv;
        sent  = 0;
        keep  = 0;
        first = 1;
        while (sent < 380)
        begin
            odds     = $urandom_range(0, 2);
            idle_pct = (odds == 0) ? 0 : (odds == 1) ? 15 : 40;
            if (!keep)
            begin
                wv = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
                hv = 16'($urandom_range(0, 6));
                set_grid(wv, hv);
            end
            cells = eff_width() * eff_height();
            if (!first && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, cells + 2 * eff_width() + 1);
                send_random_cells(n);
                sent += n;
                keep = 0;
            end
            else
            begin
                // The first frame holds back halfway until every owed result has come.
                send_frame(first);
                sent += cells + eff_width() + 1;
                keep  = ($urandom_range(0, 2) == 0);
                first = 0;
            end
        end
    endtask

    // Widest grid (written as 511, so clamped to the line buffer depth), the full width
    // written exactly, and the tallest grid; the tall ones are only partly sent.
    task automatic test_extreme_sizes();
        idle_pct = 20;
        set_grid(9'd511, 16'd1);
        send_frame(1'b0);
        set_grid(9'd256, 16'd65535);
        send_random_cells(300);
        set_grid(9'd1, 16'd65535);
        send_random_cells(40);
    endtask

    // Two frames back to back with neither side idling.
    task automatic test_full_rate();
        idle_pct = 0;
        set_grid(9'd5, 16'd4);
        send_frame(1'b0);
        send_frame(1'b0);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cell_valid   = 1'b0;
        cell_data    = '0;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        failures     = 0;
        idle_pct     = 0;
        stall_left   = 0;
        reset_shadow();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_directed_cases();
        test_random_frames();
        test_extreme_sizes();
        test_full_rate();

        wait_results_drained();
        repeat (20) @(posedge clk);
        if (failures == 0 && expected_heat.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the line buffer sweep after reset.
    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- box_filter_3x3_heat_step_core.f -----
rtl/bf3hs_pkg.sv
rtl/box_filter_3x3_heat_step_core.sv
tb/sv/box_filter_3x3_heat_step_core_tb.sv
